[src/fcba_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcba_pkg
// shared types and constants of the chained block allocator
// ----------------------------------------------------------------------------
package fcba_pkg;

    localparam int BLOCK_COUNT = 2880;
    localparam int BLOCK_BYTES = 512;

    localparam int ACT_W   = 2;
    localparam int BYTE_W  = 8;
    localparam int BLK_W   = 12;
    localparam int OFF_W   = 9;
    localparam int ST_W    = 2;
    localparam int ENTRY_W = 16;
    localparam int FILL_W  = $clog2(BLOCK_BYTES + 1);
    localparam int CNT_W   = $clog2(BLOCK_COUNT + 1);

    localparam logic [ENTRY_W-1:0] ENTRY_FREE = 16'hFFFE;
    localparam logic [ENTRY_W-1:0] ENTRY_END  = 16'hFFFF;

    typedef enum logic [ACT_W-1:0] {
        ACT_START = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [ST_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NOFILE = 2'd2,
        ST_READ   = 2'd3
    } t_status;

    typedef struct packed {
        t_action              action;
        logic [BYTE_W-1:0]    data_byte;
        logic [BLK_W-1:0]     entry_index;
    } t_item;

    typedef struct packed {
        t_status              status;
        logic [BLK_W-1:0]     block_number;
        logic [OFF_W-1:0]     byte_offset;
        logic [BYTE_W-1:0]    byte_out;
        logic                 new_block;
        logic [ENTRY_W-1:0]   entry_value;
    } t_result;

endpackage

[src/fcba_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcba_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module fcba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

[src/fcba_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcba_front
// accepts requests, drops unused action codes, two-entry queue to back end
// ----------------------------------------------------------------------------
module fcba_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    output logic           o_full,
    input  fcba_pkg::t_item i_item,
    output logic           o_valid,
    output fcba_pkg::t_item o_item,
    input  logic           i_ready
);

    fcba_pkg::t_item r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_acc, w_store, w_take;

    assign o_full  = (r_cnt == 2'd2);
    assign w_acc   = i_push && !o_full;
    assign w_store = w_acc && (i_item.action != fcba_pkg::ACT_NONE);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_take  = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_q[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_store) r_wp <= !r_wp;
            if (w_take)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_store} - {1'b0, w_take};
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("front queue count out of range");
    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_store && !w_take) |=> (r_cnt != 2'd0))
        else $error("stored request lost");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 || r_cnt == 2'd2) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with count");
`endif

endmodule

[src/fcba_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcba_back
// carries out requests against the allocation table, holds one result
// ----------------------------------------------------------------------------
module fcba_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  fcba_pkg::t_item   i_item,
    output logic              o_ready,
    output logic              o_empty,
    input  logic              i_pop,
    output fcba_pkg::t_result o_res
);

    localparam logic [fcba_pkg::CNT_W-1:0]  CntMax =
        fcba_pkg::CNT_W'(fcba_pkg::BLOCK_COUNT);
    localparam logic [fcba_pkg::FILL_W-1:0] FillMax =
        fcba_pkg::FILL_W'(fcba_pkg::BLOCK_BYTES);

    typedef enum logic [1:0] {S_IDLE, S_LINK, S_RD} t_state;

    t_state r_state, n_state;
    logic [fcba_pkg::CNT_W-1:0]  r_nf, n_nf;   // blocks used so far
    logic [fcba_pkg::BLK_W-1:0]  r_cur, n_cur;
    logic [fcba_pkg::FILL_W-1:0] r_fill, n_fill;
    logic r_open, n_open, r_oos, n_oos, r_ov, n_ov;
    fcba_pkg::t_result r_res, n_res;

    logic we, re;
    logic [fcba_pkg::BLK_W-1:0]   waddr, raddr;
    logic [fcba_pkg::ENTRY_W-1:0] wdata, rdata;
    logic [fcba_pkg::BLK_W-1:0]   nf_blk;

    assign nf_blk  = fcba_pkg::BLK_W'(r_nf);
    assign o_ready = (r_state == S_IDLE) && (!r_ov || i_pop);
    assign o_empty = !r_ov;
    assign o_res   = r_res;

    fcba_ram #(.WIDTH(fcba_pkg::ENTRY_W), .DEPTH(fcba_pkg::BLOCK_COUNT)) u_table (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_re(re), .i_raddr(raddr), .o_rdata(rdata)
    );

    always_comb begin
        n_state = r_state; n_nf = r_nf; n_cur = r_cur; n_fill = r_fill;
        n_open = r_open; n_oos = r_oos; n_res = r_res;
        n_ov = r_ov && !i_pop;
        we = 1'b0; waddr = r_cur; wdata = fcba_pkg::ENTRY_END;
        re = 1'b0; raddr = i_item.entry_index;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid && o_ready) begin
                    n_res = '0;
                    n_ov  = 1'b1;
                    unique case (i_item.action)
                        fcba_pkg::ACT_START: begin
                            if (r_nf == CntMax) begin
                                n_res.status = fcba_pkg::ST_FULL;
                                n_open = 1'b0; n_oos = 1'b1;
                            end else begin
                                we = 1'b1; waddr = nf_blk;
                                n_cur = nf_blk; n_fill = '0; n_nf = r_nf + 1'b1;
                                n_open = 1'b1; n_oos = 1'b0;
                                n_res.status = fcba_pkg::ST_OK;
                                n_res.block_number = nf_blk;
                                n_res.new_block = 1'b1;
                            end
                        end
                        fcba_pkg::ACT_BYTE: begin
                            if (r_oos) begin
                                n_res.status = fcba_pkg::ST_FULL;
                            end else if (!r_open) begin
                                n_res.status = fcba_pkg::ST_NOFILE;
                            end else if (r_fill >= FillMax) begin
                                if (r_nf == CntMax) begin
                                    n_res.status = fcba_pkg::ST_FULL;
                                    n_open = 1'b0; n_oos = 1'b1;
                                end else begin
                                    // link old block now, end mark next cycle
                                    we = 1'b1; waddr = r_cur;
                                    wdata = fcba_pkg::ENTRY_W'(r_nf);
                                    n_cur = nf_blk; n_nf = r_nf + 1'b1;
                                    n_fill = fcba_pkg::FILL_W'(1);
                                    n_state = S_LINK;
                                    n_res.status = fcba_pkg::ST_OK;
                                    n_res.block_number = nf_blk;
                                    n_res.byte_out = i_item.data_byte;
                                    n_res.new_block = 1'b1;
                                end
                            end else begin
                                n_res.status = fcba_pkg::ST_OK;
                                n_res.block_number = r_cur;
                                n_res.byte_offset = fcba_pkg::OFF_W'(r_fill);
                                n_res.byte_out = i_item.data_byte;
                                n_fill = r_fill + 1'b1;
                            end
                        end
                        fcba_pkg::ACT_READ: begin
                            n_res.status = fcba_pkg::ST_READ;
                            if (fcba_pkg::CNT_W'(i_item.entry_index) >= r_nf) begin
                                n_res.entry_value = fcba_pkg::ENTRY_FREE;
                            end else begin
                                re = 1'b1;
                                n_ov = r_ov && !i_pop;
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            n_ov = r_ov && !i_pop;
                        end
                    endcase
                end
            end
            S_LINK: begin
                we = 1'b1; waddr = r_cur; wdata = fcba_pkg::ENTRY_END;
                n_state = S_IDLE;
            end
            S_RD: begin
                n_res = '0;
                n_res.status = fcba_pkg::ST_READ;
                n_res.entry_value = rdata;
                n_ov = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_nf <= '0; r_open <= 1'b0; r_oos <= 1'b0;
            r_ov <= 1'b0; r_cur <= '0; r_fill <= '0;
        end else begin
            r_state <= n_state; r_nf <= n_nf; r_open <= n_open;
            r_oos <= n_oos; r_ov <= n_ov; r_cur <= n_cur; r_fill <= n_fill;
        end
    end

`ifndef SYNTH
    a_nf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nf <= CntMax) else $error("block count past table size");
    a_open_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_open && r_oos)) else $error("file open while out of space");
    a_cur_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open |-> (fcba_pkg::CNT_W'(r_cur) < r_nf))
        else $error("current block not allocated");
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FillMax) else $error("fill count past block size");
    a_rd_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |-> !r_ov) else $error("read reply with slot busy");
`endif

endmodule

[src/fat_chain_block_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_block_allocator
// first-fit chained allocation table that hands out disk write addresses
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// request   in         push / full        i_action, i_data_byte, i_entry_index
// result    out        empty / pop        o_status .. o_entry_value
//
// in the back end, a byte that crosses a block boundary passes through a
// link state (link write, then end-of-chain write on the single table
// write port), and a table read of a used entry passes through a read
// state (registered ram read). blocks are never freed, so the lowest free
// block is always the count of blocks used and no search is needed. entries
// at or beyond that count read as free, so reset needs no clearing pass. a
// two-entry queue lets requests arrive while the back end waits for the
// result to be popped. reset is synchronous, active low.
// ----------------------------------------------------------------------------
module fat_chain_block_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_data_byte,
    input  logic [11:0] i_entry_index,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_status,
    output logic [11:0] o_block_number,
    output logic [8:0]  o_byte_offset,
    output logic [7:0]  o_byte_out,
    output logic        o_new_block,
    output logic [15:0] o_entry_value
);

    fcba_pkg::t_item   in_item, q_item;
    fcba_pkg::t_result res;
    logic q_valid, q_ready;

    // pack the incoming request
    always_comb begin
        in_item.action      = fcba_pkg::t_action'(i_action);
        in_item.data_byte   = i_data_byte;
        in_item.entry_index = i_entry_index;
    end

    // front end: accept and classify
    fcba_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_item(in_item), .o_valid(q_valid), .o_item(q_item), .i_ready(q_ready)
    );

    // back end: table updates and the result slot
    fcba_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(q_valid), .i_item(q_item),
        .o_ready(q_ready), .o_empty(empty), .i_pop(pop), .o_res(res)
    );

    // unpack the result onto its ports
    assign o_status       = res.status;
    assign o_block_number = res.block_number;
    assign o_byte_offset  = res.byte_offset;
    assign o_byte_out     = res.byte_out;
    assign o_new_block    = res.new_block;
    assign o_entry_value  = res.entry_value;

endmodule
